[rtl/rtpfrt_pkg.sv]
// Shared types and constants of the RTP frame reassembly tracker.
`default_nettype none

package rtpfrt_pkg;

    localparam int SEQ_W   = 16;
    localparam int TS_W    = 32;
    localparam int LEN_W   = 16;
    localparam int BYTES_W = 24;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 24;

    // Operation codes of an input word.
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_CLOSE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_MAX_FRAME_BYTES = 8'd0;
    localparam logic [CIDX_W-1:0] REG_DELIVER_CORRUPT = 8'd1;

    localparam logic [BYTES_W-1:0] MAX_FRAME_RESET = {BYTES_W{1'b1}};

    typedef struct packed {
        logic               operation;
        logic [SEQ_W-1:0]   seq_number;
        logic [TS_W-1:0]    pkt_timestamp;
        logic [LEN_W-1:0]   payload_len;
    } t_item;

    typedef struct packed {
        logic [BYTES_W-1:0] max_frame_bytes;
        logic               deliver_corrupt;
    } t_cfg;

    typedef struct packed {
        logic               frame_valid;
        logic [BYTES_W-1:0] frame_bytes;
        logic [TS_W-1:0]    frame_time;
        logic               after_loss;
        logic               frame_corrupt;
        logic               gap_seen;
        logic               write_rejected;
    } t_result;

endpackage

`default_nettype wire

[rtl/rtpfrt_cfg.sv]
// Configuration registers of the RTP frame reassembly tracker.
`default_nettype none

module rtpfrt_cfg
    import rtpfrt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_write,
    input  wire logic [CIDX_W-1:0]  i_index,
    input  wire logic [CDATA_W-1:0] i_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame_bytes <= MAX_FRAME_RESET;
            r_cfg.deliver_corrupt <= 1'b0;
        end else if (i_write) begin
            unique case (i_index)
                REG_MAX_FRAME_BYTES: r_cfg.max_frame_bytes <= i_data[BYTES_W-1:0];
                REG_DELIVER_CORRUPT: r_cfg.deliver_corrupt <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/rtpfrt_track.sv]
// Sequence, timestamp and frame size tracking state with its next-state logic.
`default_nettype none

module rtpfrt_track
    import rtpfrt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_result      o_result,
    output logic         o_started,
    output logic         o_frame_nonempty
);

    logic               r_started,  n_started;
    logic [SEQ_W-1:0]   r_last_seq, n_last_seq;
    logic [TS_W-1:0]    r_cur_time, n_cur_time;
    logic [BYTES_W-1:0] r_acc,      n_acc;
    logic               r_lost,     n_lost;
    logic               r_pending,  n_pending;

    logic               gap;
    logic               closing;
    logic               lost_close;
    logic               deliver;
    logic [BYTES_W-1:0] acc_base;
    logic [BYTES_W:0]   sum;
    logic               rejected;
    t_result            res;

    always_comb begin
        n_started  = r_started;
        n_last_seq = r_last_seq;
        n_cur_time = r_cur_time;
        n_lost     = r_lost;
        n_pending  = r_pending;
        n_acc      = r_acc;
        gap        = 1'b0;
        rejected   = 1'b0;

        if (i_item.operation == OP_CLOSE) begin
            closing    = 1'b1;
            lost_close = r_lost;
        end else begin
            // Before the first packet there is no sequence to compare against,
            // and the timestamp always counts as changed.
            gap        = r_started && (i_item.seq_number != r_last_seq + SEQ_W'(1));
            closing    = !r_started || (i_item.pkt_timestamp != r_cur_time);
            lost_close = r_lost | gap;
        end

        deliver  = closing && (r_acc != '0) && (!lost_close || i_cfg.deliver_corrupt);
        acc_base = closing ? '0 : r_acc;
        sum      = {1'b0, acc_base} + {{(BYTES_W+1-LEN_W){1'b0}}, i_item.payload_len};

        res                = '0;
        res.frame_valid    = deliver;
        if (deliver) begin
            res.frame_bytes   = r_acc;
            res.frame_time    = r_cur_time;
            res.after_loss    = r_pending;
            res.frame_corrupt = lost_close;
        end

        if (closing) begin
            n_pending = deliver ? lost_close : (r_pending | lost_close);
            n_acc     = '0;
        end

        if (i_item.operation == OP_CLOSE) begin
            n_lost = 1'b0;
        end else begin
            n_started  = 1'b1;
            n_last_seq = i_item.seq_number;
            n_cur_time = i_item.pkt_timestamp;
            n_lost     = closing ? gap : lost_close;
            rejected   = sum > {1'b0, i_cfg.max_frame_bytes};
            n_acc      = rejected ? acc_base : sum[BYTES_W-1:0];
            res.gap_seen       = gap;
            res.write_rejected = rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_last_seq <= '0;
            r_cur_time <= '0;
            r_acc      <= '0;
            r_lost     <= 1'b0;
            r_pending  <= 1'b0;
        end else if (i_accept) begin
            r_started  <= n_started;
            r_last_seq <= n_last_seq;
            r_cur_time <= n_cur_time;
            r_acc      <= n_acc;
            r_lost     <= n_lost;
            r_pending  <= n_pending;
        end
    end

    assign o_result         = res;
    assign o_started        = r_started;
    assign o_frame_nonempty = (r_acc != '0);

endmodule

`default_nettype wire

[rtl/rtpfrt_outreg.sv]
// Result register of the RTP frame reassembly tracker.
`default_nettype none

module rtpfrt_outreg
    import rtpfrt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result,
    output logic         o_can_load
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

endmodule

`default_nettype wire

[rtl/rtp_frame_reassembly_tracker_top.sv]
// Top level of the RTP frame reassembly tracker.
//
// The tracker takes one word per cycle, either an RTP packet descriptor
// (sequence number, timestamp, payload length) or an end-of-frame close
// request, and returns exactly one result word for each. An item is worked
// out combinationally: the tracking state updates at the clock edge that
// accepts the word, and the result is loaded into a single output register
// at that same edge, so it appears in the cycle after acceptance. The output
// register frees itself in the cycle in which it is taken, so the tracker
// sustains one word per cycle while the downstream side keeps up; when the
// result is stalled, input ready drops until it is taken. Sequence numbers
// are checked for continuity modulo 65536, with the first packet after reset
// only seeding the check. A change of timestamp, or a close request, closes
// the current frame; a non-empty frame is reported with its size and
// timestamp unless it lost packets and corrupt delivery is switched off. A
// payload that would take the frame past max_frame_bytes is refused and
// flagged, while its sequence number and timestamp are still tracked.
// Configuration writes are always accepted and should be made while the
// tracker is idle. There is no clearing pass after reset.
`default_nettype none

module rtp_frame_reassembly_tracker_top
    import rtpfrt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_operation,
    input  wire logic [SEQ_W-1:0]   i_seq_number,
    input  wire logic [TS_W-1:0]    i_pkt_timestamp,
    input  wire logic [LEN_W-1:0]   i_payload_len,

    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_frame_valid,
    output logic [BYTES_W-1:0]      o_frame_bytes,
    output logic [TS_W-1:0]         o_frame_time,
    output logic                    o_after_loss,
    output logic                    o_frame_corrupt,
    output logic                    o_gap_seen,
    output logic                    o_write_rejected,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [CIDX_W-1:0]  i_cfg_index,
    input  wire logic [CDATA_W-1:0] i_cfg_data
);

    t_item   item;
    t_cfg    cfg;
    t_result next_result;
    t_result out_result;
    logic    can_load;
    logic    accept;
    logic    started;
    logic    frame_nonempty;

    assign item.operation     = i_operation;
    assign item.seq_number    = i_seq_number;
    assign item.pkt_timestamp = i_pkt_timestamp;
    assign item.payload_len   = i_payload_len;

    // The configuration registers never hold off a write.
    assign o_cfg_ready = 1'b1;

    rtpfrt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_write (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // A word is accepted whenever the result register is free or is being
    // emptied in this same cycle.
    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    rtpfrt_track u_track (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_item           (item),
        .i_cfg            (cfg),
        .o_result         (next_result),
        .o_started        (started),
        .o_frame_nonempty (frame_nonempty)
    );

    rtpfrt_outreg u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_result   (next_result),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_result   (out_result),
        .o_can_load (can_load)
    );

    assign o_frame_valid    = out_result.frame_valid;
    assign o_frame_bytes    = out_result.frame_bytes;
    assign o_frame_time     = out_result.frame_time;
    assign o_after_loss     = out_result.after_loss;
    assign o_frame_corrupt  = out_result.frame_corrupt;
    assign o_gap_seen       = out_result.gap_seen;
    assign o_write_rejected = out_result.write_rejected;

    // A delivered frame is never empty.
    a_frame_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_valid |-> o_frame_bytes != '0)
        else $error("delivered frame has zero size");

    // Only a delivered frame carries the corrupt or loss flags.
    a_flags_need_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_corrupt || o_after_loss) |-> o_frame_valid)
        else $error("frame flags set without a delivered frame");

    // Payload can only be counted once the first packet has been seen.
    a_bytes_need_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_nonempty |-> started)
        else $error("frame bytes counted before the first packet");

    // An accepted word always leaves a result waiting in the next cycle.
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted word produced no result");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the RTP frame reassembly tracker.
`timescale 1ns / 1ps

module testbench
    import rtpfrt_pkg::*;
();

    // Words sent after the directed part, split into phases of one setting each.
    localparam int          PHASES          = 6;
    localparam int          WORDS_PER_PHASE = 208;
    // The slowest correct word costs a sender gap, a receiver stall and its own
    // handling; the limit allows several times that for every word of the run.
    localparam int unsigned CYCLE_LIMIT     = 250000;
    localparam int          SHOWN_ERRORS    = 40;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    // One line of the directed stimulus: either a word or a register write.
    // Where typed is set, want is the result read straight off the behaviour;
    // elsewhere the word is checked against the predictor.
    typedef struct packed {
        t_row_kind          kind;
        t_item              w;
        logic               typed;
        t_result            want;
        logic [CIDX_W-1:0]  reg_idx;
        logic [CDATA_W-1:0] reg_data;
    } t_row;

    localparam t_result NO_REPORT = '0;
    localparam t_result GAP_ONLY  = '{1'b0, 24'd0, 32'd0, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam t_result REFUSED   = '{1'b0, 24'd0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam t_item   CLOSE_REQ = '{OP_CLOSE, 16'hA5A5, 32'h5A5A_5A5A, 16'hFFFF};

    // The directed part runs from reset, so both registers hold their reset
    // values until the first register row.
    localparam int   N_DIRECTED = 25;
    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // A close request before any packet finds an empty frame.
        '{ROW_WORD, CLOSE_REQ, 1'b1, NO_REPORT, '0, '0},
        // The first packet only seeds the checks; its empty frame close is silent.
        '{ROW_WORD, '{OP_PACKET, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, NO_REPORT,
          '0, '0},
        // Sequence number wraps round without a gap.
        '{ROW_WORD, '{OP_PACKET, 16'h0000, 32'hFFFF_FFFF, 16'h0000}, 1'b1, NO_REPORT,
          '0, '0},
        // Timestamp change closes the frame of 65535 bytes.
        '{ROW_WORD, '{OP_PACKET, 16'h0001, 32'h0000_0000, 16'h0001}, 1'b1,
          '{1'b1, 24'h00FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0}, '0, '0},
        '{ROW_WORD, CLOSE_REQ, 1'b1,
          '{1'b1, 24'd1, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0}, '0, '0},
        '{ROW_WORD, CLOSE_REQ, 1'b1, NO_REPORT, '0, '0},
        // A skipped sequence number marks the open frame as lost.
        '{ROW_WORD, '{OP_PACKET, 16'd3, 32'd0, 16'd10}, 1'b1, GAP_ONLY, '0, '0},
        // The lost frame is dropped and the loss is carried forward.
        '{ROW_WORD, '{OP_PACKET, 16'd4, 32'd5, 16'd20}, 1'b0, NO_REPORT, '0, '0},
        '{ROW_WORD, CLOSE_REQ, 1'b1,
          '{1'b1, 24'd20, 32'd5, 1'b1, 1'b0, 1'b0, 1'b0}, '0, '0},
        // Gap on its own, then a gap together with a timestamp change.
        '{ROW_WORD, '{OP_PACKET, 16'd10, 32'd5, 16'd7}, 1'b0, NO_REPORT, '0, '0},
        '{ROW_WORD, '{OP_PACKET, 16'd20, 32'd6, 16'd8}, 1'b0, NO_REPORT, '0, '0},
        '{ROW_WORD, CLOSE_REQ, 1'b0, NO_REPORT, '0, '0},
        '{ROW_REG, '0, 1'b0, NO_REPORT, REG_DELIVER_CORRUPT, 24'd1},
        // Empty frame closed with a gap: nothing is reported, the loss still moves on.
        '{ROW_WORD, '{OP_PACKET, 16'd30, 32'd7, 16'd0}, 1'b0, NO_REPORT, '0, '0},
        '{ROW_WORD, CLOSE_REQ, 1'b0, NO_REPORT, '0, '0},
        '{ROW_WORD, '{OP_PACKET, 16'd31, 32'd7, 16'd100}, 1'b0, NO_REPORT, '0, '0},
        // With corrupt delivery on, lost frames come out flagged.
        '{ROW_WORD, '{OP_PACKET, 16'd40, 32'd8, 16'd50}, 1'b0, NO_REPORT, '0, '0},
        '{ROW_WORD, CLOSE_REQ, 1'b0, NO_REPORT, '0, '0},
        '{ROW_REG, '0, 1'b0, NO_REPORT, REG_MAX_FRAME_BYTES, 24'd1},
        // Smallest limit: a frame may hold one byte, so any payload past it is refused.
        '{ROW_WORD, '{OP_PACKET, 16'd41, 32'd9, 16'd2}, 1'b1, REFUSED, '0, '0},
        '{ROW_WORD, '{OP_PACKET, 16'd42, 32'd9, 16'd1}, 1'b0, NO_REPORT, '0, '0},
        '{ROW_WORD, '{OP_PACKET, 16'd43, 32'd9, 16'd1}, 1'b1, REFUSED, '0, '0},
        '{ROW_WORD, CLOSE_REQ, 1'b0, NO_REPORT, '0, '0},
        '{ROW_REG, '0, 1'b0, NO_REPORT, REG_MAX_FRAME_BYTES, 24'hFFFFFF},
        '{ROW_REG, '0, 1'b0, NO_REPORT, REG_DELIVER_CORRUPT, 24'd0}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_operation;
    logic [SEQ_W-1:0]    i_seq_number;
    logic [TS_W-1:0]     i_pkt_timestamp;
    logic [LEN_W-1:0]    i_payload_len;
    logic                o_valid;
    logic                i_ready;
    logic                o_frame_valid;
    logic [BYTES_W-1:0]  o_frame_bytes;
    logic [TS_W-1:0]     o_frame_time;
    logic                o_after_loss;
    logic                o_frame_corrupt;
    logic                o_gap_seen;
    logic                o_write_rejected;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index;
    logic [CDATA_W-1:0]  i_cfg_data;

    // Tracking state of the predictor, held at its reset values to begin with.
    logic                trk_started = 1'b0;
    logic [SEQ_W-1:0]    trk_last_seq = '0;
    logic [TS_W-1:0]     trk_time = '0;
    logic [BYTES_W-1:0]  trk_bytes = '0;
    logic                trk_lost = 1'b0;
    logic                trk_pending = 1'b0;
    logic [BYTES_W-1:0]  cfg_max = MAX_FRAME_RESET;
    logic                cfg_corrupt = 1'b0;

    // Results still owed by the tracker, oldest first.
    t_result             reports_due [$];

    // Random packet stream: the next sequence number and timestamp in order.
    logic [SEQ_W-1:0]    gen_seq = '0;
    logic [TS_W-1:0]     gen_ts = '0;
    int unsigned         len_cap = 65535;
    // While set, neither side idles.
    logic                steady = 1'b0;

    int unsigned         cycle_count = 0;
    int unsigned         n_errors = 0;
    int unsigned         n_checked = 0;
    int unsigned         n_words = 0;
    int unsigned         n_closes = 0;
    int unsigned         n_frames = 0;
    int unsigned         n_corrupt = 0;
    int unsigned         n_gaps = 0;
    int unsigned         n_refused = 0;
    int unsigned         n_settings = 0;

    rtp_frame_reassembly_tracker_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_seq_number     (i_seq_number),
        .i_pkt_timestamp  (i_pkt_timestamp),
        .i_payload_len    (i_payload_len),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_valid    (o_frame_valid),
        .o_frame_bytes    (o_frame_bytes),
        .o_frame_time     (o_frame_time),
        .o_after_loss     (o_after_loss),
        .o_frame_corrupt  (o_frame_corrupt),
        .o_gap_seen       (o_gap_seen),
        .o_write_rejected (o_write_rejected),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The watchdog ends a run that hangs, for instance on a lost handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results owed.",
                     cycle_count, reports_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Closes the frame being built. A frame with payload is reported unless it
    // lost packets and corrupt delivery is off; its loss is always carried on to
    // the next reported frame.
    function automatic t_result retire_frame(t_result r);
        if (trk_bytes != '0 && (!trk_lost || cfg_corrupt)) begin
            r.frame_valid   = 1'b1;
            r.frame_bytes   = trk_bytes;
            r.frame_time    = trk_time;
            r.after_loss    = trk_pending;
            r.frame_corrupt = trk_lost;
            trk_pending     = 1'b0;
        end
        if (trk_lost)
            trk_pending = 1'b1;
        trk_lost  = 1'b0;
        trk_bytes = '0;
        return r;
    endfunction

    // Works out the result of one word and moves the tracking state on.
    function automatic t_result track_word(t_item w);
        t_result            r;
        logic               gap;
        logic [SEQ_W-1:0]   next_seq;
        logic [BYTES_W:0]   sum;
        r   = '0;
        gap = 1'b0;
        if (w.operation == OP_CLOSE)
            return retire_frame(r);
        // The first packet seeds the checks so that it is always in order and
        // always opens a fresh frame.
        if (!trk_started) begin
            trk_started  = 1'b1;
            trk_last_seq = w.seq_number - 16'd1;
            trk_time     = w.pkt_timestamp + 32'd1;
        end
        next_seq = trk_last_seq + 16'd1;
        if (w.seq_number != next_seq) begin
            gap      = 1'b1;
            trk_lost = 1'b1;
        end
        trk_last_seq = w.seq_number;
        // A gap seen together with a new timestamp spoils both frames.
        if (w.pkt_timestamp != trk_time) begin
            r = retire_frame(r);
            if (gap)
                trk_lost = 1'b1;
        end
        trk_time = w.pkt_timestamp;
        sum = {1'b0, trk_bytes} + {{(BYTES_W+1-LEN_W){1'b0}}, w.payload_len};
        if (sum > {1'b0, cfg_max})
            r.write_rejected = 1'b1;
        else
            trk_bytes = sum[BYTES_W-1:0];
        r.gap_seen = gap;
        return r;
    endfunction

    // Most random words continue a well-formed packet stream: consecutive
    // sequence numbers, frames of a few packets each. The rest are skips,
    // repeats, close requests and words of wholly random content.
    function automatic t_item next_word();
        t_item       w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        w.operation     = OP_PACKET;
        w.seq_number    = 16'($urandom_range(0, 65535));
        w.pkt_timestamp = $urandom;
        w.payload_len   = 16'($urandom_range(0, 65535));
        if (pick < 8) begin
            w.operation = OP_CLOSE;
        end else if (pick >= 13) begin
            if (pick < 17)
                gen_seq = gen_seq + 16'($urandom_range(2, 300));
            else if (pick >= 19)
                gen_seq = gen_seq + 16'd1;
            if ($urandom_range(0, 5) == 0)
                gen_ts = gen_ts + 32'($urandom_range(1, 4000));
            else if ($urandom_range(0, 60) == 0)
                gen_ts = $urandom;
            w.seq_number    = gen_seq;
            w.pkt_timestamp = gen_ts;
            if ($urandom_range(0, 9) == 0)
                w.payload_len = '0;
            else
                w.payload_len = 16'($urandom_range(0, len_cap));
        end
        return w;
    endfunction

    // Cycles a side waits before its next word; none at all while steady.
    function automatic int unsigned draw_pause();
        if (steady || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= SHOWN_ERRORS)
            $display("Mismatch at result %0d: %s", n_checked, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Offers one word, waits for it to be taken and records what it owes.
    task automatic send_word(input t_item w, input logic typed, input t_result want);
        int unsigned pause;
        t_result     predicted;
        pause = draw_pause();
        if (pause != 0) begin
            i_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= w.operation;
        i_seq_number    <= w.seq_number;
        i_pkt_timestamp <= w.pkt_timestamp;
        i_payload_len   <= w.payload_len;
        do @(posedge i_clk); while (!o_ready);
        // The word was taken at this edge, so the state moves on now.
        predicted = track_word(w);
        reports_due.push_back(typed ? want : predicted);
        n_words++;
        n_closes  += 32'(w.operation == OP_CLOSE);
        n_frames  += 32'(predicted.frame_valid);
        n_corrupt += 32'(predicted.frame_corrupt);
        n_gaps    += 32'(predicted.gap_seen);
        n_refused += 32'(predicted.write_rejected);
    endtask

    // Leaves the tracker idle: no word offered and nothing still owed.
    task automatic drain_results();
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CIDX_W-1:0] idx,
                                  input logic [CDATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MAX_FRAME_BYTES: cfg_max = data[BYTES_W-1:0];
            REG_DELIVER_CORRUPT: cfg_corrupt = data[0];
            default: ;
        endcase
        n_settings++;
    endtask

    // Receiving side: stalls at random before each result, then checks it
    // field by field against the oldest result owed.
    initial begin
        t_result got;
        t_result want;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int unsigned stall;
            stall = draw_pause();
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = '{o_frame_valid, o_frame_bytes, o_frame_time, o_after_loss,
                    o_frame_corrupt, o_gap_seen, o_write_rejected};
            n_checked++;
            if (reports_due.size() == 0) begin
                report_mismatch("result arrived with no word outstanding");
            end else begin
                want = reports_due.pop_front();
                compare_field("frame_valid", 32'(got.frame_valid),
                              32'(want.frame_valid));
                compare_field("frame_bytes", 32'(got.frame_bytes),
                              32'(want.frame_bytes));
                compare_field("frame_time", got.frame_time, want.frame_time);
                compare_field("after_loss", 32'(got.after_loss),
                              32'(want.after_loss));
                compare_field("frame_corrupt", 32'(got.frame_corrupt),
                              32'(want.frame_corrupt));
                compare_field("gap_seen", 32'(got.gap_seen), 32'(want.gap_seen));
                compare_field("write_rejected", 32'(got.write_rejected),
                              32'(want.write_rejected));
            end
        end
    end

    // Sending side and run control.
    initial begin
        t_row              row;
        logic [BYTES_W-1:0] new_max;
        logic              new_corrupt;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_operation     <= OP_PACKET;
        i_seq_number    <= '0;
        i_pkt_timestamp <= '0;
        i_payload_len   <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_MAX_FRAME_BYTES;
        i_cfg_data      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Register rows wait for the tracker to go idle first.
        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED_ROWS[k];
            if (row.kind == ROW_REG) begin
                drain_results();
                write_register(row.reg_idx, row.reg_data);
            end else begin
                i_cfg_valid <= 1'b0;
                send_word(row.w, row.typed, row.want);
            end
        end

        // Random part. Each phase runs under its own setting, the extremes of
        // the size limit among them; payload sizes follow the limit so that
        // refusals come up where the limit is low enough to reach.
        gen_seq = 16'($urandom_range(0, 65535));
        gen_ts  = $urandom;
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    new_max = MAX_FRAME_RESET;
                    new_corrupt = 1'b0;
                    len_cap = 65535;
                end
                1: begin
                    new_max = 24'd1;
                    new_corrupt = 1'b1;
                    len_cap = 2;
                end
                2: begin
                    new_max = 24'($urandom_range(2, 4000));
                    new_corrupt = 1'b0;
                    len_cap = 32'(new_max);
                end
                3: begin
                    new_max = 24'($urandom_range(65536, 400000));
                    new_corrupt = 1'b1;
                    len_cap = 65535;
                end
                4: begin
                    new_max = MAX_FRAME_RESET;
                    new_corrupt = 1'b1;
                    len_cap = 65535;
                end
                default: begin
                    new_max = 24'($urandom_range(1, 24'hFFFFFF));
                    new_corrupt = 1'($urandom_range(0, 1));
                    len_cap = 65535;
                end
            endcase
            write_register(REG_MAX_FRAME_BYTES, new_max);
            write_register(REG_DELIVER_CORRUPT, {23'd0, new_corrupt});
            i_cfg_valid <= 1'b0;
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // Now and then both sides run flat out for a stretch.
                if (k % 100 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                // Occasionally hold the sender back until every result is in.
                if ($urandom_range(0, 199) == 0)
                    drain_results();
                send_word(next_word(), 1'b0, NO_REPORT);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d words (%0d close requests) over %0d register writes.",
                 n_words, n_closes, n_settings);
        $display("Summary: %0d frames reported (%0d corrupt), %0d gaps, %0d refusals.",
                 n_frames, n_corrupt, n_gaps, n_refused);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/rtpfrt_pkg.sv
rtl/rtpfrt_cfg.sv
rtl/rtpfrt_track.sv
rtl/rtpfrt_outreg.sv
rtl/rtp_frame_reassembly_tracker_top.sv
bench/testbench.sv
